[hw/rtl/cbot_pkg.sv]
package cbot_pkg;

  // Field widths fixed by the transaction format.
  localparam int MODE_W  = 2;
  localparam int COORD_W = 16;
  localparam int SIZE_W  = 15;

  // Derived datapath widths.
  localparam int DIST_W = COORD_W + 1;     // doubled absolute centre distance
  localparam int EXT_W  = SIZE_W + 1;      // summed or single extent / radius
  localparam int LIM_W  = EXT_W + 2;       // extent plus doubled radius
  localparam int SQ_W   = 2 * DIST_W;      // square of a corner offset

  typedef logic [MODE_W-1:0] mode_t;

  // Shape pair codes.
  localparam mode_t MODE_BOX_BOX   = 2'd0;
  localparam mode_t MODE_CIRC_BOX  = 2'd1;
  localparam mode_t MODE_BOX_CIRC  = 2'd2;
  localparam mode_t MODE_CIRC_CIRC = 2'd3;

endpackage

[hw/rtl/circle_box_overlap_test.sv]
// Overlap test for two planar shapes, four register stages deep.
// The result strobe out_valid is registered and follows the stage valid bits v1_r, v2_r, v3_r in turn.
// Throughput: one transaction per cycle; busy is tied low because the receiver cannot stall.
// The pace is set by the corner test: squaring in stage three, summing and comparing in four.
// Reset (rst_n low, synchronous) clears the stage valid bits only; payload registers are not
// reset, and no result strobe is raised for anything accepted before reset.
module circle_box_overlap_test (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [cbot_pkg::MODE_W-1:0]         in_mode,
  input  logic signed [cbot_pkg::COORD_W-1:0] in_a_x,
  input  logic signed [cbot_pkg::COORD_W-1:0] in_a_y,
  input  logic [cbot_pkg::SIZE_W-1:0]         in_a_w,
  input  logic [cbot_pkg::SIZE_W-1:0]         in_a_h,
  input  logic signed [cbot_pkg::COORD_W-1:0] in_b_x,
  input  logic signed [cbot_pkg::COORD_W-1:0] in_b_y,
  input  logic [cbot_pkg::SIZE_W-1:0]         in_b_w,
  input  logic [cbot_pkg::SIZE_W-1:0]         in_b_h,
  output logic                                out_valid,
  output logic                                out_overlap
);

  // All three pair kinds are folded onto one circle-box test on doubled
  // distances X = 2|dx| and Y = 2|dy| against an extent w, h and radius r:
  //   reject when X > w + 2r or Y > h + 2r,
  //   accept when X <= w or Y <= h,
  //   otherwise accept when (X - w)^2 + (Y - h)^2 <= (2r)^2.
  // A box pair is that test with r = 0 and the summed extents, which
  // reduces to the two slab compares. A circle pair is that test with
  // w = h = 0 and r the summed radii, which reduces to the squared
  // distance compare, all lengths doubled.

  localparam int DW = cbot_pkg::DIST_W;
  localparam int EW = cbot_pkg::EXT_W;
  localparam int LW = cbot_pkg::LIM_W;
  localparam int QW = cbot_pkg::SQ_W;

  logic accept_in;

  // Stage 1: absolute distances and operand selection.
  logic signed [DW-1:0] diff_x, diff_y;
  logic [DW-2:0]        abs_x, abs_y;
  logic [EW-1:0]        w_nxt, h_nxt, r_nxt;

  logic                 v1_r;
  logic [DW-1:0]        x1_r, y1_r;
  logic [EW-1:0]        w1_r, h1_r, r1_r;

  // Stage 2: prune, slab and corner offsets.
  logic [DW-1:0]        rr_nxt;
  logic [LW-1:0]        lim_x, lim_y;
  logic                 reject_nxt, slab_nxt;
  logic [DW-1:0]        cx_nxt, cy_nxt;

  logic                 v2_r, reject2_r, slab2_r;
  logic [DW-1:0]        cx2_r, cy2_r, rr2_r;

  // Stage 3: squares.
  logic [QW-1:0]        sqx_nxt, sqy_nxt, sqr_nxt;

  logic                 v3_r, reject3_r, slab3_r;
  logic [QW-1:0]        sqx3_r, sqy3_r, sqr3_r;

  // Stage 4: corner compare and final flag.
  logic                 corner;
  logic                 overlap_nxt;
  logic                 out_valid_r, out_overlap_r;

  // The pipeline never stalls, so a transaction is taken whenever start is high.
  assign busy      = 1'b0;
  assign accept_in = start && !busy;

  // ---------------------------------------------------------------- stage 1
  always_comb begin
    diff_x = {in_a_x[cbot_pkg::COORD_W-1], in_a_x} - {in_b_x[cbot_pkg::COORD_W-1], in_b_x};
    diff_y = {in_a_y[cbot_pkg::COORD_W-1], in_a_y} - {in_b_y[cbot_pkg::COORD_W-1], in_b_y};
    // The magnitude of a 17-bit difference of 16-bit values fits in 16 bits.
    abs_x  = diff_x[DW-1] ? (DW-1)'(-diff_x) : diff_x[DW-2:0];
    abs_y  = diff_y[DW-1] ? (DW-1)'(-diff_y) : diff_y[DW-2:0];
  end

  always_comb begin
    unique case (in_mode)
      cbot_pkg::MODE_BOX_BOX: begin
        w_nxt = {1'b0, in_a_w} + {1'b0, in_b_w};
        h_nxt = {1'b0, in_a_h} + {1'b0, in_b_h};
        r_nxt = '0;
      end
      cbot_pkg::MODE_CIRC_BOX: begin
        w_nxt = {1'b0, in_b_w};
        h_nxt = {1'b0, in_b_h};
        r_nxt = {1'b0, in_a_w};
      end
      cbot_pkg::MODE_BOX_CIRC: begin
        w_nxt = {1'b0, in_a_w};
        h_nxt = {1'b0, in_a_h};
        r_nxt = {1'b0, in_b_w};
      end
      default: begin
        // Two circles: a point against a circle of the summed radii.
        w_nxt = '0;
        h_nxt = '0;
        r_nxt = {1'b0, in_a_w} + {1'b0, in_b_w};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept_in;
    end
  end

  always_ff @(posedge clk) begin
    x1_r <= {abs_x, 1'b0};
    y1_r <= {abs_y, 1'b0};
    w1_r <= w_nxt;
    h1_r <= h_nxt;
    r1_r <= r_nxt;
  end

  // ---------------------------------------------------------------- stage 2
  always_comb begin
    rr_nxt     = {r1_r, 1'b0};
    lim_x      = LW'(w1_r) + LW'(rr_nxt);
    lim_y      = LW'(h1_r) + LW'(rr_nxt);
    reject_nxt = (LW'(x1_r) > lim_x) || (LW'(y1_r) > lim_y);
    slab_nxt   = (x1_r <= DW'(w1_r)) || (y1_r <= DW'(h1_r));
    // Only used when both distances lie beyond the extents and within
    // the prune limits, where the offsets are at most 2r and fit.
    cx_nxt     = x1_r - DW'(w1_r);
    cy_nxt     = y1_r - DW'(h1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    reject2_r <= reject_nxt;
    slab2_r   <= slab_nxt;
    cx2_r     <= cx_nxt;
    cy2_r     <= cy_nxt;
    rr2_r     <= rr_nxt;
  end

  // ---------------------------------------------------------------- stage 3
  always_comb begin
    sqx_nxt = QW'(cx2_r) * QW'(cx2_r);
    sqy_nxt = QW'(cy2_r) * QW'(cy2_r);
    sqr_nxt = QW'(rr2_r) * QW'(rr2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    reject3_r <= reject2_r;
    slab3_r   <= slab2_r;
    sqx3_r    <= sqx_nxt;
    sqy3_r    <= sqy_nxt;
    sqr3_r    <= sqr_nxt;
  end

  // ---------------------------------------------------------------- stage 4
  always_comb begin
    corner      = ((QW + 1)'(sqx3_r) + (QW + 1)'(sqy3_r)) <= (QW + 1)'(sqr3_r);
    overlap_nxt = !reject3_r && (slab3_r || corner);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    out_overlap_r <= overlap_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_overlap = out_overlap_r;

`ifndef SYNTHESIS
  // Every accepted transaction produces a result strobe.
  a_accept_gives_result: assert property (
    @(posedge clk) disable iff (!rst_n)
    accept_in |-> ##4 out_valid
  ) else $error("accepted transaction produced no result");

  // No result strobe appears without a matching accepted transaction.
  a_no_spurious_result: assert property (
    @(posedge clk) disable iff (!rst_n)
    !accept_in |-> ##4 !out_valid
  ) else $error("result strobe without an accepted transaction");

  // A pair pruned on the expanded extents must come out as no overlap.
  a_reject_is_clear: assert property (
    @(posedge clk) disable iff (!rst_n)
    (v2_r && reject2_r) |-> ##2 (out_valid && !out_overlap)
  ) else $error("pruned pair reported as overlapping");
`endif

endmodule
